// ----- rtl/bicubic_half_downsampler_defines.svh -----
// Assertion macros shared by the RTL.
`ifndef BICUBIC_HALF_DOWNSAMPLER_DEFINES_SVH
`define BICUBIC_HALF_DOWNSAMPLER_DEFINES_SVH

`ifndef SYNTH
`define BHD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define BHD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define BHD_ASSERT(lbl, clk, rstn, prop, msg)
`define BHD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/bhd_pkg.sv -----
`default_nettype none

package bhd_pkg;

    localparam int NUM_LANES  = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int CFG_W      = 4;
    localparam int WLOG_MIN   = 2;

    localparam logic REG_WIDTH_LOG2    = 1'b0;
    localparam logic REG_FOUR_CHANNELS = 1'b1;

    // tap placement at the image edges
    typedef enum logic [1:0] {
        EM_NORM,
        EM_FIRST,
        EM_LAST
    } edge_mode_t;

    typedef struct packed {
        logic       emit;
        logic       four_ch;
        edge_mode_t rmode;
        edge_mode_t cmode;
        logic [8:0] ox;
        logic [8:0] oy;
    } ctrl_t;

    typedef struct packed {
        logic [NUM_LANES-1:0][7:0] px;
        logic [8:0]                col;
        logic [8:0]                row;
    } result_t;

    function automatic logic [1:0] sel_idx(edge_mode_t m, logic [1:0] i);
        logic [1:0] r;
        case (m)
            EM_FIRST: r = (i == 2'd0) ? 2'd1 : i;
            EM_LAST:  r = (i == 2'd3) ? 2'd3 : i + 2'd1;
            default:  r = i;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bhd_ifs.sv -----
`default_nettype none

interface bhd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_0;
    logic [7:0] chan_1;
    logic [7:0] chan_2;
    logic [7:0] chan_3;

    modport source (output valid, chan_0, chan_1, chan_2, chan_3, input ready);
    modport sink (input valid, chan_0, chan_1, chan_2, chan_3, output ready);
endinterface

interface bhd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] res_0;
    logic [7:0] res_1;
    logic [7:0] res_2;
    logic [7:0] res_3;
    logic [8:0] out_col;
    logic [8:0] out_row;
    logic       run_last;

    modport source (output valid, res_0, res_1, res_2, res_3, out_col, out_row, run_last,
                    input ready);
    modport sink (input valid, res_0, res_1, res_2, res_3, out_col, out_row, run_last,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/bhd_lane.sv -----
`default_nettype none

// One channel of the separable filter: vertical taps, then horizontal taps,
// round half up and clamp. Two register stages.
module bhd_lane (
    input  logic       clk,
    input  logic [7:0] px [4][4],
    output logic [7:0] res
);
    logic signed [12:0] v_reg [4];
    logic signed [12:0] v_next [4];
    logic signed [15:0] s;
    logic signed [16:0] t;
    logic [7:0]         res_reg;
    logic [7:0]         res_next;

    always_comb
    begin
        for (int a = 0; a < 4; a++)
        begin
            v_next[a] = 13'(5) * ($signed({5'b0, px[a][1]}) + $signed({5'b0, px[a][2]}))
                        - $signed({5'b0, px[a][0]}) - $signed({5'b0, px[a][3]});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 4; a++)
        begin
            v_reg[a] <= v_next[a];
        end
        res_reg <= res_next;
    end

    always_comb
    begin
        s = 16'(5) * (16'(v_reg[1]) + 16'(v_reg[2])) - 16'(v_reg[0]) - 16'(v_reg[3]);
        t = 17'(s) + 17'sd32;
        if (t[16])
            res_next = 8'd0;
        else if (|t[15:14])
            res_next = 8'd255;
        else
            res_next = t[13:6];
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- rtl/bicubic_half_downsampler.sv -----
`default_nettype none
`include "bicubic_half_downsampler_defines.svh"

// Half-size bicubic downsampler. Pixels arrive in raster order, one per item,
// on a square image of 2**width_log2 columns; each result is the 4x4 filter
// (-1,5,5,-1)/8 in both directions with edge clamping, rounded and clamped to
// a byte. One pixel is taken per cycle while the input is not stalled; the
// four channels run in parallel lanes and the three previous rows live in
// three single-port-write, registered-read line memories addressed by column;
// a result passes the stage-1 registers and the two lane stages. A four-entry
// result queue takes results while the output is stalled; input stalls only
// when that queue plus the results still in the pipeline fill it. No clearing
// pass runs after reset.
module bicubic_half_downsampler #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [bhd_pkg::CFG_W-1:0] cfg_data,
    bhd_pix_if.sink                   pixel,
    bhd_res_if.source                 result
);
    import bhd_pkg::*;

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int LOG_FLOOR = $clog2(MAX_WIDTH + 1) - 1;
    localparam int LOG_TOP   = (LOG_FLOOR > 12) ? 12 : LOG_FLOOR;
    localparam int FW        = $clog2(FIFO_DEPTH);

    logic [CFG_W-1:0] wlog_reg;
    logic             four_reg;
    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    row_reg;
    logic [1:0]       m3_reg;

    logic [CFG_W-1:0] lg;
    logic [CW:0]      wfull;
    logic [CW-1:0]    wlast;
    logic [CW-1:0]    half_m1;
    logic [CW-1:0]    c;
    logic [CW-1:0]    r;
    logic [1:0]       m3;
    logic             acc;
    logic [31:0]      pix;
    logic             row_done;
    logic             col_done;
    ctrl_t            ctrl_now;

    always_comb
    begin
        if (wlog_reg < CFG_W'(WLOG_MIN))
            lg = CFG_W'(WLOG_MIN);
        else if (wlog_reg > CFG_W'(LOG_TOP))
            lg = CFG_W'(LOG_TOP);
        else
            lg = wlog_reg;
        wfull   = (CW+1)'(1) << lg;
        wlast   = CW'(wfull - (CW+1)'(1));
        half_m1 = CW'((wfull >> 1) - (CW+1)'(1));
        if (col_reg > wlast || row_reg > wlast)
        begin
            c  = '0;
            r  = '0;
            m3 = 2'd0;
        end
        else
        begin
            c  = col_reg;
            r  = row_reg;
            m3 = m3_reg;
        end
    end

    assign acc = pixel.valid && pixel.ready;
    assign pix = {pixel.chan_3, pixel.chan_2, pixel.chan_1, pixel.chan_0};

    always_comb
    begin
        row_done = (!r[0] && |r[CW-1:1]) || r == wlast;
        col_done = (!c[0] && |c[CW-1:1]) || c == wlast;
        ctrl_now.emit    = row_done && col_done;
        ctrl_now.four_ch = four_reg;
        if (r == wlast)
            ctrl_now.rmode = EM_LAST;
        else if (r == CW'(2))
            ctrl_now.rmode = EM_FIRST;
        else
            ctrl_now.rmode = EM_NORM;
        if (c == wlast)
            ctrl_now.cmode = EM_LAST;
        else if (c == CW'(2))
            ctrl_now.cmode = EM_FIRST;
        else
            ctrl_now.cmode = EM_NORM;
        ctrl_now.ox = (c == wlast) ? 9'(half_m1) : 9'(CW'(c >> 1) - CW'(1));
        ctrl_now.oy = (r == wlast) ? 9'(half_m1) : 9'(CW'(r >> 1) - CW'(1));
    end

    // position counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlog_reg <= CFG_W'(WLOG_MIN);
            four_reg <= 1'b1;
            col_reg  <= '0;
            row_reg  <= '0;
            m3_reg   <= 2'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH_LOG2:
                begin
                    wlog_reg <= cfg_data;
                    col_reg  <= '0;
                    row_reg  <= '0;
                    m3_reg   <= 2'd0;
                end
                REG_FOUR_CHANNELS: four_reg <= cfg_data[0];
                default: ;
            endcase
        end
        else if (acc)
        begin
            if (c == wlast)
            begin
                col_reg <= '0;
                if (r == wlast)
                begin
                    row_reg <= '0;
                    m3_reg  <= 2'd0;
                end
                else
                begin
                    row_reg <= r + CW'(1);
                    m3_reg  <= (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
                end
            end
            else
            begin
                col_reg <= c + CW'(1);
                row_reg <= r;
                m3_reg  <= m3;
            end
        end
    end

    // line memories, one per row slot (row mod 3)
    logic [31:0] rd_reg [3];

    for (genvar g = 0; g < 3; g++)
    begin : g_line
        logic [31:0] mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (acc && m3 == 2'(g))
                mem[c] <= pix;
            if (acc)
                rd_reg[g] <= mem[c];
        end
    end

    // stage 1: column vector and window
    logic        v1_reg;
    logic [31:0] pix1_reg;
    logic [1:0]  m31_reg;
    ctrl_t       ctrl1_reg;
    logic        e1;
    logic [31:0] colv [4];
    logic [31:0] win_reg [3][4];
    logic [31:0] cols [4][4];
    logic [31:0] sel [4][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= acc;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            pix1_reg  <= pix;
            m31_reg   <= m3;
            ctrl1_reg <= ctrl_now;
        end
    end

    assign e1 = v1_reg && ctrl1_reg.emit;

    always_comb
    begin
        case (m31_reg)
            2'd0:
            begin
                colv[0] = rd_reg[0];
                colv[1] = rd_reg[1];
                colv[2] = rd_reg[2];
            end
            2'd1:
            begin
                colv[0] = rd_reg[1];
                colv[1] = rd_reg[2];
                colv[2] = rd_reg[0];
            end
            default:
            begin
                colv[0] = rd_reg[2];
                colv[1] = rd_reg[0];
                colv[2] = rd_reg[1];
            end
        endcase
        colv[3] = pix1_reg;
        for (int j = 0; j < 4; j++)
        begin
            cols[0][j] = win_reg[2][j];
            cols[1][j] = win_reg[1][j];
            cols[2][j] = win_reg[0][j];
            cols[3][j] = colv[j];
        end
        for (int a = 0; a < 4; a++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                sel[a][b] = cols[sel_idx(ctrl1_reg.cmode, 2'(a))]
                                [sel_idx(ctrl1_reg.rmode, 2'(b))];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (v1_reg)
        begin
            for (int j = 0; j < 4; j++)
            begin
                win_reg[2][j] <= win_reg[1][j];
                win_reg[1][j] <= win_reg[0][j];
                win_reg[0][j] <= colv[j];
            end
        end
    end

    // channel lanes
    logic [7:0] lane_res [NUM_LANES];

    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        logic [7:0] lpx [4][4];

        always_comb
        begin
            for (int a = 0; a < 4; a++)
            begin
                for (int b = 0; b < 4; b++)
                begin
                    lpx[a][b] = sel[a][b][8*k +: 8];
                end
            end
        end

        bhd_lane u_lane (
            .clk (clk),
            .px  (lpx),
            .res (lane_res[k])
        );
    end

    // control follows the lane stages
    logic  e2_reg;
    logic  e3_reg;
    ctrl_t ctrl2_reg;
    ctrl_t ctrl3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e2_reg <= 1'b0;
            e3_reg <= 1'b0;
        end
        else
        begin
            e2_reg <= e1;
            e3_reg <= e2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl2_reg <= ctrl1_reg;
        ctrl3_reg <= ctrl2_reg;
    end

    // merge lanes into a result and queue it
    result_t         fifo_reg [FIFO_DEPTH];
    logic [FW-1:0]   head_reg;
    logic [FW-1:0]   tail_reg;
    logic [FW:0]     fifo_cnt_reg;
    logic [FW:0]     inflight;
    logic            push;
    logic            pop;
    result_t         merged;

    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            merged.px[k] = (k == 0 || ctrl3_reg.four_ch) ? lane_res[k] : 8'd0;
        end
        merged.col = ctrl3_reg.ox;
        merged.row = ctrl3_reg.oy;
    end

    assign push     = e3_reg;
    assign pop      = result.valid && result.ready;
    assign inflight = (FW+1)'(e1) + (FW+1)'(e2_reg) + (FW+1)'(e3_reg);

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[tail_reg] <= merged;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (push)
                tail_reg <= tail_reg + FW'(1);
            if (pop)
                head_reg <= head_reg + FW'(1);
            fifo_cnt_reg <= fifo_cnt_reg + (FW+1)'(push) - (FW+1)'(pop);
        end
    end

    assign pixel.ready     = (fifo_cnt_reg + inflight) < (FW+1)'(FIFO_DEPTH);
    assign result.valid    = fifo_cnt_reg != '0;
    assign result.res_0    = fifo_reg[head_reg].px[0];
    assign result.res_1    = fifo_reg[head_reg].px[1];
    assign result.res_2    = fifo_reg[head_reg].px[2];
    assign result.res_3    = fifo_reg[head_reg].px[3];
    assign result.out_col  = fifo_reg[head_reg].col;
    assign result.out_row  = fifo_reg[head_reg].row;
    assign result.run_last = 1'b1;

    `BHD_ASSERT(a_credit, clk, rst_n, (fifo_cnt_reg + inflight) <= (FW+1)'(FIFO_DEPTH), "queue credit exceeded")
    `BHD_ASSERT(a_no_overflow, clk, rst_n, !(push && !pop && fifo_cnt_reg == (FW+1)'(FIFO_DEPTH)), "push into full queue")
    `BHD_ASSERT_NEXT(a_emit_tracks, clk, rst_n, acc && ctrl_now.emit, e1, "emitting item lost in stage 1")

endmodule

`default_nettype wire

// ----- test/bhd_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none

module bhd_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [bhd_pkg::CFG_W-1:0] cfg_data,
    bhd_pix_if                        pixel,
    bhd_res_if                        result,
    output int                        errors,
    output int                        pending
);
    import bhd_pkg::*;

    localparam int LINE_W = 1024;

    typedef struct {
        logic [7:0] px [4];
        logic [8:0] col;
        logic [8:0] row;
    } out_pixel_t;

    out_pixel_t  out_pixels_due[$];
    logic [31:0] rows_seen [3*LINE_W];
    logic [31:0] col_hist [12];
    int unsigned col_pos, row_pos;
    logic [3:0]  wlog;
    logic        four_ch;

    assign pending = out_pixels_due.size();

    function automatic logic [7:0] round_byte(int s);
        int t;
        t = s + 32;
        if (t < 0) return 8'd0;
        t = t >>> 6;
        if (t > 255) return 8'd255;
        return t[7:0];
    endfunction

    function automatic int tap(int i);
        return (i == 0 || i == 3) ? -1 : 5;
    endfunction

    // one pixel into the filter model; pushes a result when one is finished
    task automatic filter_pixel(input logic [31:0] pix);
        int unsigned w, c, r, lg, ox, oy;
        logic [31:0] colv [4];
        logic [31:0] win [4][4];
        int rsel [4];
        int csel [4];
        int s, v;
        bit row_done, col_done;
        out_pixel_t o;
        lg = (wlog < 2) ? 2 : (wlog > 10) ? 10 : wlog;
        w = 1 << lg;
        c = col_pos;
        r = row_pos;
        if (c >= w || r >= w) begin
            c = 0;
            r = 0;
        end
        colv[0] = rows_seen[(r % 3) * LINE_W + c];
        colv[1] = rows_seen[((r + 1) % 3) * LINE_W + c];
        colv[2] = rows_seen[((r + 2) % 3) * LINE_W + c];
        colv[3] = pix;
        rows_seen[(r % 3) * LINE_W + c] = pix;
        for (int j = 0; j < 4; j++) begin
            win[0][j] = col_hist[8 + j];
            win[1][j] = col_hist[4 + j];
            win[2][j] = col_hist[j];
            win[3][j] = colv[j];
            rsel[j] = j;
            csel[j] = j;
        end
        row_done = ((r % 2) == 0 && r >= 2) || r == w - 1;
        col_done = ((c % 2) == 0 && c >= 2) || c == w - 1;
        if (row_done && col_done) begin
            oy = (r == w - 1) ? (w / 2 - 1) : (r / 2 - 1);
            ox = (c == w - 1) ? (w / 2 - 1) : (c / 2 - 1);
            // edge clamping of the tap positions
            if (r == w - 1) begin
                rsel = '{1, 2, 3, 3};
            end
            else if (r == 2) begin
                rsel[0] = 1;
            end
            if (c == w - 1) begin
                csel = '{1, 2, 3, 3};
            end
            else if (c == 2) begin
                csel[0] = 1;
            end
            for (int k = 0; k < 4; k++) begin
                if (k == 0 || four_ch) begin
                    s = 0;
                    for (int a = 0; a < 4; a++) begin
                        v = 0;
                        for (int b = 0; b < 4; b++)
                            v += tap(b) * int'((win[csel[a]][rsel[b]] >> (8 * k)) & 32'hFF);
                        s += tap(a) * v;
                    end
                    o.px[k] = round_byte(s);
                end
                else begin
                    o.px[k] = 8'd0;
                end
            end
            o.col = ox[8:0];
            o.row = oy[8:0];
            out_pixels_due.push_back(o);
        end
        for (int j = 0; j < 4; j++) begin
            col_hist[8 + j] = col_hist[4 + j];
            col_hist[4 + j] = col_hist[j];
            col_hist[j] = colv[j];
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= w) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic check_result();
        out_pixel_t e;
        bit bad;
        if (out_pixels_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result col %0d row %0d", result.out_col, result.out_row);
            return;
        end
        e = out_pixels_due.pop_front();
        bad = result.res_0 !== e.px[0] || result.res_1 !== e.px[1] ||
              result.res_2 !== e.px[2] || result.res_3 !== e.px[3] ||
              result.out_col !== e.col || result.out_row !== e.row ||
              result.run_last !== 1'b1;
        if (bad) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp %h %h %h %h c%0d r%0d l1, got %h %h %h %h c%0d r%0d l%b",
                         e.px[0], e.px[1], e.px[2], e.px[3], e.col, e.row,
                         result.res_0, result.res_1, result.res_2, result.res_3,
                         result.out_col, result.out_row, result.run_last);
        end
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < 3 * LINE_W; i++) rows_seen[i] = '0;
            for (int i = 0; i < 12; i++) col_hist[i] = '0;
            col_pos = 0;
            row_pos = 0;
            wlog = 4'd2;
            four_ch = 1'b1;
            out_pixels_due.delete();
        end
        else begin
            if (result.valid && result.ready)
                check_result();
            if (cfg_we) begin
                if (cfg_index == REG_WIDTH_LOG2) begin
                    wlog = cfg_data;
                    col_pos = 0;
                    row_pos = 0;
                end
                else begin
                    four_ch = cfg_data[0];
                end
            end
            if (pixel.valid && pixel.ready)
                filter_pixel({pixel.chan_3, pixel.chan_2, pixel.chan_1, pixel.chan_0});
        end
    end
endmodule

`default_nettype wire

// ----- test/bicubic_half_downsampler_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none

module bicubic_half_downsampler_tb;
    import bhd_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    int                  errors;
    int                  pending;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    bhd_pix_if pixel ();
    bhd_res_if result ();

    bicubic_half_downsampler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .pixel    (pixel),
        .result   (result)
    );

    bhd_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .pixel    (pixel),
        .result   (result),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
        result.ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_pixel(input logic [31:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            pixel.valid <= 1'b0;
            @(posedge clk);
        end
        pixel.valid  <= 1'b1;
        pixel.chan_0 <= p[7:0];
        pixel.chan_1 <= p[15:8];
        pixel.chan_2 <= p[23:16];
        pixel.chan_3 <= p[31:24];
        do @(posedge clk); while (!pixel.ready);
    endtask

    // sender holds off until all results are out, then the pipeline drains
    task automatic drain();
        pixel.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_pixels(input int n);
        for (int i = 0; i < n; i++)
            send_pixel({pick_byte(), pick_byte(), pick_byte(), pick_byte()});
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_WIDTH_LOG2;
        cfg_data     = '0;
        pixel.valid  = 1'b0;
        pixel.chan_0 = '0;
        pixel.chan_1 = '0;
        pixel.chan_2 = '0;
        pixel.chan_3 = '0;
        result.ready = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 84;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // width below range saturates to 4; checkerboard of extremes
        write_reg(REG_WIDTH_LOG2, 4'd0);
        write_reg(REG_FOUR_CHANNELS, 4'd1);
        for (int i = 0; i < 16; i++) begin
            if (((i % 4) + (i / 4)) % 2 == 0)
                send_pixel(32'hFF00FF00);
            else
                send_pixel(32'h00FF00FF);
        end
        drain();

        // width above range saturates to the largest; no result that early
        write_reg(REG_WIDTH_LOG2, 4'd15);
        write_reg(REG_FOUR_CHANNELS, 4'd0);
        send_pixel(32'hFFFFFFFF);
        send_pixel(32'h00000000);
        random_pixels(6);
        drain();

        for (int m = 0; m < 3; m++) begin
            send_idle_pct = (m == 0) ? 26 : (m == 1) ? 84 : 0;
            recv_idle_pct = (m == 0) ? 84 : (m == 1) ? 26 : 0;
            case (m)
                0: begin
                    write_reg(REG_WIDTH_LOG2, 4'd3);
                    write_reg(REG_FOUR_CHANNELS, 4'd0);
                    random_pixels(64);
                end
                1: begin
                    write_reg(REG_WIDTH_LOG2, 4'd2);
                    write_reg(REG_FOUR_CHANNELS, 4'd1);
                    random_pixels(64);
                end
                default: begin
                    write_reg(REG_WIDTH_LOG2, 4'd3);
                    write_reg(REG_FOUR_CHANNELS, 4'd1);
                    random_pixels(80);
                end
            endcase
            drain();
        end

        if (errors == 0)
            $display("bicubic_half_downsampler_tb: done, clean");
        else
            $display("bicubic_half_downsampler_tb: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("bicubic_half_downsampler_tb: done, errors");
        $finish;
    end
endmodule

`default_nettype wire
